// ===== rtl/i2cm_pkg.sv =====
// shared codes and widths for the i2c master byte engine
package i2cm_pkg;

    localparam int CMD_W   = 3;
    localparam int PHASE_W = 4;
    localparam int DELAY_W = 10;
    localparam int STR_W   = 8;
    localparam int BITC_W  = 4;
    localparam int CFG_IDX_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_NONE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_RECOVER = 3'd5;

    // sequencer phases
    localparam logic [PHASE_W-1:0] PH_IDLE  = 4'd0;
    localparam logic [PHASE_W-1:0] PH_REL   = 4'd1;
    localparam logic [PHASE_W-1:0] PH_CHK   = 4'd2;
    localparam logic [PHASE_W-1:0] PH_S_SDA = 4'd3;
    localparam logic [PHASE_W-1:0] PH_S_SCL = 4'd4;
    localparam logic [PHASE_W-1:0] PH_P_SDA = 4'd5;
    localparam logic [PHASE_W-1:0] PH_W_BIT = 4'd6;
    localparam logic [PHASE_W-1:0] PH_W_LOW = 4'd7;
    localparam logic [PHASE_W-1:0] PH_W_SMP = 4'd8;
    localparam logic [PHASE_W-1:0] PH_R_SMP = 4'd9;
    localparam logic [PHASE_W-1:0] PH_R_END = 4'd10;
    localparam logic [PHASE_W-1:0] PH_V_LOW = 4'd11;
    localparam logic [PHASE_W-1:0] PH_FIN   = 4'd12;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_STRETCH = 2'd1;
    localparam logic [1:0] ST_BUSY    = 2'd2;
    localparam logic [1:0] ST_NACK    = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRETCH_LIMIT = 2'd1;

    localparam logic [DELAY_W-1:0] HALF_PERIOD_RST   = 10'd5;
    localparam logic [STR_W-1:0]   STRETCH_LIMIT_RST = 8'd100;
    localparam logic [BITC_W-1:0]  DATA_BITS         = 4'd8;
    localparam logic [BITC_W-1:0]  RECOVER_PULSES    = 4'd9;

endpackage

// ===== rtl/i2c_master_byte_engine.sv =====
// i2c master byte engine: tick-driven command sequencer with registered result
// the result for a tick request is registered and shown in the cycle after it is accepted
// throughput: one tick request per cycle; in_stall rises only while the result
// register is full and out_stall holds it
// a command spans the configured half period per delay, counted in accepted tick requests
// reset: async active low, lines released, idle, half period 5, stretch limit 100
module i2c_master_byte_engine
    import i2cm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // tick request channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [CMD_W-1:0]     command,
    input  logic [7:0]           write_data,
    input  logic                 ack_after_read,
    input  logic                 scl_in,
    input  logic                 sda_in,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 scl_drive_low,
    output logic                 sda_drive_low,
    output logic                 busy_res,
    output logic                 done_res,
    output logic [1:0]           status,
    output logic [7:0]           read_data,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DELAY_W-1:0]   cfg_data
);

    logic [DELAY_W-1:0] half_reg;
    logic [STR_W-1:0]   stretch_reg;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [DELAY_W-1:0] delay_reg, delay_next;
    logic [STR_W-1:0]   str_reg, str_next;
    logic [7:0]         shift_reg, shift_next;
    logic [BITC_W-1:0]  bit_reg, bit_next;
    logic               ack_reg, ack_next;
    logic               scl_low_reg, scl_low_next;
    logic               sda_low_reg, sda_low_next;
    logic [1:0]         status_reg, status_next;
    logic [7:0]         read_reg, read_next;
    logic               done_reg, done_next;
    logic               out_valid_reg;

    logic               in_accept;
    logic               act;
    logic               stop_like;
    logic               fin;
    logic [1:0]         fin_status;

    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    assign out_valid     = out_valid_reg;
    assign scl_drive_low = scl_low_reg;
    assign sda_drive_low = sda_low_reg;
    assign busy_res      = (phase_reg != PH_IDLE);
    assign done_res      = done_reg;
    assign status        = status_reg;
    assign read_data     = read_reg;

    assign stop_like = (cmd_reg == CMD_STOP) ||
                       ((cmd_reg == CMD_RECOVER) && (bit_reg >= RECOVER_PULSES));

    always_comb
    begin
        phase_next   = phase_reg;
        cmd_next     = cmd_reg;
        delay_next   = delay_reg;
        str_next     = str_reg;
        shift_next   = shift_reg;
        bit_next     = bit_reg;
        ack_next     = ack_reg;
        scl_low_next = scl_low_reg;
        sda_low_next = sda_low_reg;
        status_next  = status_reg;
        read_next    = read_reg;
        done_next    = 1'b0;
        act          = 1'b0;
        fin          = 1'b0;
        fin_status   = ST_OK;

        if (phase_reg == PH_IDLE)
        begin
            // codes above recover are ignored
            if ((command >= CMD_START) && (command <= CMD_RECOVER))
            begin
                cmd_next    = command;
                status_next = ST_OK;
                str_next    = '0;
                bit_next    = '0;
                delay_next  = half_reg;
                phase_next  = PH_REL;
                unique case (command)
                    CMD_START:
                    begin
                        sda_low_next = 1'b0;
                        scl_low_next = 1'b0;
                        delay_next   = '0;
                        phase_next   = PH_CHK;
                    end
                    CMD_STOP:
                    begin
                        sda_low_next = 1'b1;
                    end
                    CMD_WRITE:
                    begin
                        shift_next   = write_data;
                        sda_low_next = ~write_data[7];
                    end
                    CMD_READ:
                    begin
                        shift_next   = '0;
                        ack_next     = ack_after_read;
                        sda_low_next = 1'b0;
                    end
                    default:
                    begin
                        sda_low_next = 1'b0;
                        scl_low_next = 1'b1;
                    end
                endcase
            end
        end
        else
        begin
            act = 1'b1;
            if (delay_reg != '0)
            begin
                delay_next = delay_reg - 1'b1;
                if (delay_next != '0)
                    act = 1'b0;
            end
        end

        if (act)
        begin
            unique case (phase_reg)
                PH_REL:
                begin
                    scl_low_next = 1'b0;
                    str_next     = '0;
                    phase_next   = PH_CHK;
                end
                PH_CHK:
                begin
                    if (str_reg >= stretch_reg)
                    begin
                        if (stop_like)
                        begin
                            // timeout during a stop, also the stop that ends a recovery, is not reported
                            sda_low_next = 1'b0;
                            delay_next   = half_reg;
                            phase_next   = PH_FIN;
                        end
                        else if ((cmd_reg == CMD_READ) && (bit_reg >= DATA_BITS))
                        begin
                            // read still completes, flagged as a timeout
                            status_next  = ST_STRETCH;
                            scl_low_next = 1'b1;
                            sda_low_next = 1'b0;
                            delay_next   = half_reg;
                            phase_next   = PH_FIN;
                        end
                        else
                        begin
                            fin        = 1'b1;
                            fin_status = ST_STRETCH;
                        end
                    end
                    else if (!scl_in)
                    begin
                        // slave still holds the clock low
                        str_next   = str_reg + 1'b1;
                        delay_next = half_reg;
                        phase_next = PH_CHK;
                    end
                    else
                    begin
                        delay_next = half_reg;
                        unique case (cmd_reg)
                            CMD_START:   phase_next = PH_S_SDA;
                            CMD_STOP:    phase_next = PH_P_SDA;
                            CMD_WRITE:   phase_next = (bit_reg < DATA_BITS) ?
                                                      PH_W_LOW : PH_W_SMP;
                            CMD_READ:    phase_next = (bit_reg < DATA_BITS) ?
                                                      PH_R_SMP : PH_R_END;
                            CMD_RECOVER: phase_next = (bit_reg < RECOVER_PULSES) ?
                                                      PH_V_LOW : PH_P_SDA;
                            default:
                            begin
                                phase_next = PH_IDLE;
                                delay_next = '0;
                            end
                        endcase
                    end
                end
                PH_S_SDA:
                begin
                    if (!sda_in)
                    begin
                        fin        = 1'b1;
                        fin_status = ST_BUSY;
                    end
                    else
                    begin
                        sda_low_next = 1'b1;
                        delay_next   = half_reg;
                        phase_next   = PH_S_SCL;
                    end
                end
                PH_S_SCL:
                begin
                    scl_low_next = 1'b1;
                    delay_next   = half_reg;
                    phase_next   = PH_FIN;
                end
                PH_P_SDA:
                begin
                    sda_low_next = 1'b0;
                    delay_next   = half_reg;
                    phase_next   = PH_FIN;
                end
                PH_W_BIT:
                begin
                    // ninth bit releases sda for the acknowledge
                    sda_low_next = (bit_reg < DATA_BITS) ? ~shift_reg[7] : 1'b0;
                    delay_next   = half_reg;
                    phase_next   = PH_REL;
                end
                PH_W_LOW:
                begin
                    scl_low_next = 1'b1;
                    shift_next   = {shift_reg[6:0], 1'b0};
                    bit_next     = bit_reg + 1'b1;
                    delay_next   = half_reg;
                    phase_next   = PH_W_BIT;
                end
                PH_W_SMP:
                begin
                    scl_low_next = 1'b1;
                    if (sda_in)
                    begin
                        fin        = 1'b1;
                        fin_status = ST_NACK;
                    end
                    else
                    begin
                        delay_next = half_reg;
                        phase_next = PH_FIN;
                    end
                end
                PH_R_SMP:
                begin
                    shift_next   = {shift_reg[6:0], sda_in};
                    scl_low_next = 1'b1;
                    bit_next     = bit_reg + 1'b1;
                    if (bit_next >= DATA_BITS)
                        sda_low_next = ack_reg;
                    delay_next   = half_reg;
                    phase_next   = PH_REL;
                end
                PH_R_END:
                begin
                    scl_low_next = 1'b1;
                    sda_low_next = 1'b0;
                    delay_next   = half_reg;
                    phase_next   = PH_FIN;
                end
                PH_V_LOW:
                begin
                    scl_low_next = 1'b1;
                    bit_next     = bit_reg + 1'b1;
                    // after the last pulse hold sda low to set up the stop
                    if (bit_next >= RECOVER_PULSES)
                        sda_low_next = 1'b1;
                    delay_next   = half_reg;
                    phase_next   = PH_REL;
                end
                PH_FIN:
                begin
                    fin        = 1'b1;
                    fin_status = status_reg;
                    if (cmd_reg == CMD_RECOVER)
                        fin_status = sda_in ? ST_OK : ST_BUSY;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    delay_next = '0;
                end
            endcase
        end

        if (fin)
        begin
            status_next = fin_status;
            if (cmd_reg == CMD_READ)
                read_next = shift_reg;
            phase_next = PH_IDLE;
            delay_next = '0;
            done_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg    <= HALF_PERIOD_RST;
            stretch_reg <= STRETCH_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HALF_PERIOD:   half_reg    <= cfg_data;
                CFG_STRETCH_LIMIT: stretch_reg <= cfg_data[STR_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            cmd_reg     <= CMD_NONE;
            delay_reg   <= '0;
            str_reg     <= '0;
            shift_reg   <= '0;
            bit_reg     <= '0;
            ack_reg     <= 1'b0;
            scl_low_reg <= 1'b0;
            sda_low_reg <= 1'b0;
            status_reg  <= ST_OK;
            read_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else if (in_accept)
        begin
            phase_reg   <= phase_next;
            cmd_reg     <= cmd_next;
            delay_reg   <= delay_next;
            str_reg     <= str_next;
            shift_reg   <= shift_next;
            bit_reg     <= bit_next;
            ack_reg     <= ack_next;
            scl_low_reg <= scl_low_next;
            sda_low_reg <= sda_low_next;
            status_reg  <= status_next;
            read_reg    <= read_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (phase_reg == PH_IDLE))
        else $error("done shown while a command is still running");

    a_idle_no_delay: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (delay_reg == '0))
        else $error("delay counter left running in idle");

    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_reg <= RECOVER_PULSES)
        else $error("bit counter past the recovery pulse count");

    a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted tick request produced no result");

    a_hold_state: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(phase_reg) && $stable(bit_reg))
        else $error("sequencer state moved without a tick request");

endmodule
